// ===== rtl/delta_gap_bit_packer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Delta-gap bit packer assertion macros
// Clocked, reset-qualified assertion wrappers for the packer's checks.
// ----------------------------------------------------------------------------
`ifndef DELTA_GAP_BIT_PACKER_TOP_DEFINES_SVH
`define DELTA_GAP_BIT_PACKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Assert prop at every rising edge of clk outside reset
`define DGBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Assert that cond never holds at a rising edge of clk outside reset
`define DGBP_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DGBP_ASSERT(label, prop, msg)
`define DGBP_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/dgbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Delta-gap bit packer package
// Widths, word types, mode codes and the bit count function.
// ----------------------------------------------------------------------------
`default_nettype none

package dgbp_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned FILL_W    = 5;
	localparam int unsigned CNT_W     = 6;

	localparam logic MODE_VALUE = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic                 mode;
		logic [WORD_BITS-1:0] value;
		logic                 list_start;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0]     gap_bits;
		logic                 word_valid;
		logic [WORD_BITS-1:0] packed_word;
	} result_t;

	// Position of the highest set bit plus one; zero for a zero operand
	function automatic logic [CNT_W-1:0] sig_bits(input logic [WORD_BITS-1:0] x);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (x[i]) begin
				n = CNT_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dgbp_core.sv =====
// ----------------------------------------------------------------------------
// Delta-gap bit packer core
// Holds the list and accumulator state and forms one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module dgbp_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire dgbp_pkg::item_t item,
	output dgbp_pkg::result_t    res
);
	import dgbp_pkg::*;

	logic [WORD_BITS-1:0]   prev_q;
	logic [WORD_BITS-1:0]   acc_q;
	logic [FILL_W-1:0]      fill_q;
	logic [WORD_BITS-1:0]   prev_d;
	logic [WORD_BITS-1:0]   acc_d;
	logic [FILL_W-1:0]      fill_d;
	logic [WORD_BITS-1:0]   base;
	logic [WORD_BITS-1:0]   gap;
	logic [CNT_W-1:0]       nbits;
	logic [CNT_W-1:0]       total;
	logic [2*WORD_BITS-1:0] merged;

	always_comb begin
		base   = item.list_start ? '0 : prev_q;
		gap    = item.value - base;
		nbits  = sig_bits(gap);
		total  = CNT_W'(fill_q) + nbits;
		// low half completes the word, high half is the spill into the next
		merged = ((2*WORD_BITS)'(gap) << fill_q) | (2*WORD_BITS)'(acc_q);

		res    = '0;
		prev_d = prev_q;
		acc_d  = acc_q;
		fill_d = fill_q;

		case (item.mode)
			MODE_FLUSH: begin
				if (fill_q != '0) begin
					res.word_valid  = 1'b1;
					res.packed_word = acc_q;
				end
				acc_d  = '0;
				fill_d = '0;
			end
			MODE_VALUE: begin
				res.gap_bits = nbits;
				prev_d       = item.value;
				if (total >= CNT_W'(WORD_BITS)) begin
					res.word_valid  = 1'b1;
					res.packed_word = merged[WORD_BITS-1:0];
					acc_d           = merged[2*WORD_BITS-1:WORD_BITS];
				end else begin
					acc_d = merged[WORD_BITS-1:0];
				end
				fill_d = total[FILL_W-1:0];
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			acc_q  <= '0;
			fill_q <= '0;
		end else if (advance) begin
			prev_q <= prev_d;
			acc_q  <= acc_d;
			fill_q <= fill_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/delta_gap_bit_packer_top.sv =====
// One item is taken in every cycle while in_stall is low and gives exactly one result, through
// an input register and a result register with the gap, bit count and shift-merge between them.
// The accumulator and previous-value registers feed back around that single stage, so a list
// value or flush may follow any other in the next cycle. A stall on the result side holds the
// result register and, once the input register is also full, raises in_stall.
// ----------------------------------------------------------------------------
// Delta-gap bit packer top level
// Input register, packing core and result register with valid/stall flow.
// ----------------------------------------------------------------------------
`default_nettype none
`include "delta_gap_bit_packer_top_defines.svh"

module delta_gap_bit_packer_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           mode,
	input  wire logic [dgbp_pkg::WORD_BITS-1:0] value,
	input  wire logic                           list_start,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [dgbp_pkg::CNT_W-1:0]          gap_bits,
	output logic                                word_valid,
	output logic [dgbp_pkg::WORD_BITS-1:0]      packed_word
);
	import dgbp_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t res;
	logic    out_ready;
	logic    advance;
	logic    cnt_full;
	logic    cnt_over;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	dgbp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.res     (res)
	);

	// input register: hold while the stage is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{mode: mode, value: value, list_start: list_start};
		end
	end

	// result register: advance whenever the far side takes the word or it is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign gap_bits    = result_q.gap_bits;
	assign word_valid  = result_q.word_valid;
	assign packed_word = result_q.packed_word;

	assign cnt_full = (gap_bits == CNT_W'(WORD_BITS));
	assign cnt_over = (gap_bits > CNT_W'(WORD_BITS));

	`DGBP_ASSERT(a_full_gap_emits, (out_valid && cnt_full) |-> word_valid, "full gap, no word")
	`DGBP_ASSERT(a_idle_word_zero, (out_valid && !word_valid) |-> (packed_word == '0), "stale word")
	`DGBP_ASSERT_NEVER(a_count_range, out_valid && cnt_over, "bit count out of range")
	`DGBP_ASSERT_NEVER(a_stall_cause, in_stall && !(out_valid && out_stall), "stall without cause")

endmodule

`default_nettype wire
